FILE: src/lrg_pkg.sv
// lrg_pkg: shared widths, codes and reset values of the linear ramp generator
// used by the channel interfaces and the top level
`timescale 1ns / 1ps

package lrg_pkg;

	localparam int unsigned VAL_W        = 32;
	localparam int unsigned GRAN_W       = 16;
	localparam int unsigned RTIME_W      = 24;
	localparam int unsigned MODE_W       = 2;
	localparam int unsigned TIME_BITS_DEF = 24;
	localparam int unsigned DIV_W        = VAL_W + 1;
	localparam int unsigned STEP_W       = DIV_W + 1;
	localparam int unsigned SUM_W        = STEP_W + 1;

	localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(20);

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK = 2'd0,
		MODE_GO   = 2'd1,
		MODE_SET  = 2'd2,
		MODE_STOP = 2'd3
	} mode_t;

endpackage

FILE: src/lrg_if.sv
// lrg_if: command and ramp output channels with valid/ready handshake
// depends on lrg_pkg for field widths
`timescale 1ns / 1ps

interface lrg_cmd_if;
	import lrg_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic signed [VAL_W-1:0] value;
	logic [RTIME_W-1:0]      ramp_time_ms;

	modport source (output valid, output mode, output value, output ramp_time_ms, input ready);
	modport sink (input valid, input mode, input value, input ramp_time_ms, output ready);
endinterface

interface lrg_ramp_if;
	import lrg_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_out;
	logic                    last;

	modport source (output valid, output value_out, output last, input ready);
	modport sink (input valid, input value_out, input last, output ready);
endinterface

FILE: src/linear_ramp_generator_unit.sv
// linear_ramp_generator_unit: top level of the linear ramp generator
// a tick during a running ramp moves to the step state and registers its ramp point once the output is free;
// a go first runs two passes of the shared bit-serial divider (grain count, then step) and then steps alike
// commands are taken only in idle, so a new command waits until the previous one has finished
// reset: arst_n clears the ramp state to zero and idle, granularity to 20
// depends on lrg_pkg, lrg_if and lrg_div
`timescale 1ns / 1ps

module linear_ramp_generator_unit #(
	parameter int unsigned TIME_BITS = lrg_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [lrg_pkg::GRAN_W-1:0] cfg_wr_data,
	lrg_cmd_if.sink                    cmd,
	lrg_ramp_if.source                 ramp
);
	import lrg_pkg::*;

	localparam int unsigned DVS_W = (TIME_BITS > GRAN_W) ? TIME_BITS : GRAN_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV1 = 4'b0010,
		ST_DIV2 = 4'b0100,
		ST_STEP = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [GRAN_W-1:0]       gran_q;
	logic signed [VAL_W-1:0] cur_q;
	logic signed [VAL_W-1:0] target_q;
	logic [STEP_W-1:0]       step_q;
	logic [TIME_BITS-1:0]    grains_q;
	logic                    running_q;
	logic [DIV_W-1:0]        dist_q;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        out_value_q;
	logic                    out_last_q;

	logic                    cmd_fire;
	mode_t                   mode;
	logic [TIME_BITS-1:0]    rtime;
	logic [GRAN_W-1:0]       gran_eff;
	logic [TIME_BITS-1:0]    count;
	logic [TIME_BITS-1:0]    count_fix;
	logic [DIV_W-1:0]        dist_mag;
	logic [STEP_W-1:0]       step_n;
	logic                    div_start;
	logic [DIV_W-1:0]        div_dividend;
	logic [DVS_W-1:0]        div_divisor;
	logic                    div_busy;
	logic                    div_done;
	logic [DIV_W-1:0]        div_quo;
	logic [SUM_W-1:0]        sum;
	logic [VAL_W-1:0]        sum_sat;
	logic [TIME_BITS-1:0]    grains_dec;
	logic                    last_n;
	logic                    out_free;
	logic                    step_fire;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign mode      = mode_t'(cmd.mode);
	assign rtime     = TIME_BITS'(cmd.ramp_time_ms);
	assign gran_eff  = (gran_q == '0) ? GRAN_W'(1) : gran_q;

	assign count     = div_quo[TIME_BITS-1:0];
	assign count_fix = (count == '0) ? TIME_BITS'(1) : count;
	assign dist_mag  = dist_q[DIV_W-1] ? (~dist_q + DIV_W'(1)) : dist_q;
	assign step_n    = dist_q[DIV_W-1] ? (~{1'b0, div_quo} + STEP_W'(1)) : {1'b0, div_quo};

	assign div_start    = (cmd_fire && mode == MODE_GO) || (state_q == ST_DIV1 && div_done);
	assign div_dividend = (state_q == ST_DIV1) ? dist_mag : DIV_W'(rtime);
	assign div_divisor  = (state_q == ST_DIV1) ? DVS_W'(count_fix) : DVS_W'(gran_eff);

	lrg_div #(
		.DIV_W (DIV_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// running sum with saturation to the 32-bit signed range
	always_comb begin
		sum = {{(SUM_W-VAL_W){cur_q[VAL_W-1]}}, cur_q} + {step_q[STEP_W-1], step_q};
		if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
			sum_sat = sum[VAL_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
		grains_dec = grains_q - TIME_BITS'(1);
		last_n     = (grains_dec == '0);
	end

	assign out_free  = !out_valid_q || ramp.ready;
	assign step_fire = (state_q == ST_STEP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gran_q      <= GRAN_RESET;
			cur_q       <= '0;
			target_q    <= '0;
			step_q      <= '0;
			grains_q    <= '0;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				gran_q <= cfg_wr_data;
			end
			if (step_fire) begin
				out_valid_q <= 1'b1;
			end else if (ramp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (mode)
							MODE_TICK: begin
								if (running_q) begin
									state_q <= ST_STEP;
								end
							end
							MODE_GO: begin
								target_q <= cmd.value;
								state_q  <= ST_DIV1;
							end
							MODE_SET: begin
								running_q <= 1'b0;
								cur_q     <= cmd.value;
							end
							default: begin
								running_q <= 1'b0;
							end
						endcase
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						grains_q <= count_fix;
						state_q  <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						step_q    <= step_n;
						running_q <= 1'b1;
						state_q   <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (out_free) begin
						grains_q <= grains_dec;
						if (last_n) begin
							cur_q     <= target_q;
							running_q <= 1'b0;
						end else begin
							cur_q <= sum_sat;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// distance to go and the result register
	always_ff @(posedge clk) begin
		if (cmd_fire && mode == MODE_GO) begin
			dist_q <= {cmd.value[VAL_W-1], cmd.value} - {cur_q[VAL_W-1], cur_q};
		end
		if (step_fire) begin
			out_value_q <= last_n ? target_q : sum_sat;
			out_last_q  <= last_n;
		end
	end

	assign ramp.valid     = out_valid_q;
	assign ramp.value_out = out_value_q;
	assign ramp.last      = out_last_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !div_busy)
		else $error("command accepted while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider done outside a division state");

	a_run_grains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && running_q) |-> grains_q != '0)
		else $error("running with no grains left");

	a_last_snaps: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && last_n) |=> (!running_q && ramp.value_out == $past(target_q)))
		else $error("last transaction did not reach the target");

endmodule

FILE: src/lrg_div.sv
// lrg_div: shared restoring divider, one quotient bit per cycle
// unsigned operands; depends on nothing outside this file
`timescale 1ns / 1ps

module lrg_div #(
	parameter int unsigned DIV_W = 33,
	parameter int unsigned DVS_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   shf;
	logic [DVS_W:0]   dif;
	logic             ge;
	logic [DVS_W-1:0] rem_n;

	always_comb begin
		shf   = {rem_q, quo_q[DIV_W-1]};
		dif   = shf - {1'b0, dvs_q};
		ge    = (shf >= {1'b0, dvs_q});
		rem_n = ge ? dif[DVS_W-1:0] : shf[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for linear_ramp_generator_unit with a bit-accurate
// ramp predictor, bursty command driver, stalling output sink and granularity sweeps
// depends on lrg_pkg, lrg_if and the linear_ramp_generator_unit rtl
`timescale 1ns / 1ps

module testbench;
	import lrg_pkg::*;

	localparam int unsigned TB_TIME_BITS = 24;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS = 250;
	localparam int NUM_PHASES = 7;
	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;
	localparam logic signed [VAL_W-1:0] LEVEL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VAL_W-1:0] LEVEL_MIN = 32'sh80000000;
	localparam logic [RTIME_W-1:0] RTIME_MAX = 24'hFFFFFF;

	typedef struct {
		mode_t                   mode;
		logic signed [VAL_W-1:0] value;
		logic [RTIME_W-1:0]      ramp_time_ms;
	} ramp_cmd_t;

	typedef struct {
		logic signed [VAL_W-1:0] value_out;
		logic                    last;
	} ramp_point_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [GRAN_W-1:0] cfg_wr_data;

	lrg_cmd_if cmd_ch ();
	lrg_ramp_if ramp_ch ();

	linear_ramp_generator_unit #(
		.TIME_BITS(TB_TIME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd(cmd_ch),
		.ramp(ramp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ramp_cmd_t pending_cmds[$];
	ramp_point_t ramp_expected[$];
	ramp_cmd_t cmd_in_flight;

	// predictor state
	logic signed [VAL_W-1:0]  level_now;
	logic signed [VAL_W-1:0]  level_target;
	logic signed [STEP_W-1:0] level_step;
	logic [TB_TIME_BITS-1:0]  grains_left;
	bit                       ramping;
	logic [GRAN_W-1:0]        gran_copy;

	int errors = 0;
	int cycles = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_left = 0;
	int rx_mode = 0;
	int hold_left = 0;
	int holds_done = 0;

	function automatic void step_level();
		longint sum;
		ramp_point_t pt;
		sum = longint'(level_now) + longint'(level_step);
		if (sum > VAL_MAX)
			level_now = LEVEL_MAX;
		else if (sum < VAL_MIN)
			level_now = LEVEL_MIN;
		else
			level_now = sum[VAL_W-1:0];
		grains_left = grains_left - 1'b1;
		pt.last = 1'b0;
		if (grains_left == '0) begin
			level_now = level_target;
			ramping = 1'b0;
			pt.last = 1'b1;
		end
		pt.value_out = level_now;
		ramp_expected.push_back(pt);
	endfunction

	function automatic void predict_ramp(ramp_cmd_t c);
		longint gran_eff;
		longint count;
		longint span;
		case (c.mode)
			MODE_TICK: begin
				if (ramping)
					step_level();
			end
			MODE_GO: begin
				gran_eff = (gran_copy == '0) ? 1 : longint'(gran_copy);
				count = longint'(c.ramp_time_ms) / gran_eff;
				if (count == 0)
					count = 1;
				level_target = c.value;
				span = longint'(level_target) - longint'(level_now);
				level_step = STEP_W'(span / count);
				grains_left = TB_TIME_BITS'(count);
				ramping = 1'b1;
				step_level();
			end
			MODE_SET: begin
				ramping = 1'b0;
				level_now = c.value;
			end
			default: begin
				ramping = 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gran_copy <= GRAN_RESET;
		end else if (cfg_wr_en) begin
			gran_copy <= cfg_wr_data;
		end
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			level_now = '0;
			level_target = '0;
			level_step = '0;
			grains_left = '0;
			ramping = 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_ramp(cmd_in_flight);
				items_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd_in_flight = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.mode <= cmd_in_flight.mode;
					cmd_ch.value <= cmd_in_flight.value;
					cmd_ch.ramp_time_ms <= cmd_in_flight.ramp_time_ms;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 7))
							0, 1, 2, 3: gap_left = 0;
							4, 5: gap_left = $urandom_range(1, 4);
							6: gap_left = $urandom_range(5, 30);
							default: gap_left = $urandom_range(60, 150);
						endcase
					end
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// output sink with its own stall pattern and two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_ch.ready <= 1'b0;
			rx_left = 0;
			rx_mode = 0;
			hold_left = 0;
			holds_done = 0;
		end else begin
			if (hold_left == 0 && holds_done < 2 &&
					results_seen >= ((holds_done == 0) ? 100 : 600)) begin
				hold_left = 400;
				holds_done++;
			end
			if (rx_left == 0) begin
				rx_left = $urandom_range(16, 300);
				rx_mode = $urandom_range(0, 3);
			end else begin
				rx_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				ramp_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: ramp_ch.ready <= 1'b1;
					1: ramp_ch.ready <= 1'($urandom_range(0, 1));
					2: ramp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: ramp_ch.ready <= ~ramp_ch.ready;
				endcase
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		ramp_point_t want;
		if (arst_n && ramp_ch.valid && ramp_ch.ready) begin
			if (ramp_expected.size() == 0) begin
				$display("%0t: unexpected transaction value_out=%0d last=%0b",
					$time, ramp_ch.value_out, ramp_ch.last);
				errors++;
			end else begin
				want = ramp_expected.pop_front();
				if (ramp_ch.value_out !== want.value_out) begin
					$display("%0t: value_out mismatch expected=%0d actual=%0d",
						$time, want.value_out, ramp_ch.value_out);
					errors++;
				end
				if (ramp_ch.last !== want.last) begin
					$display("%0t: last mismatch expected=%0b actual=%0b",
						$time, want.last, ramp_ch.last);
					errors++;
				end
			end
			results_seen <= results_seen + 1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic push_cmd(mode_t m, logic signed [VAL_W-1:0] v, logic [RTIME_W-1:0] t);
		ramp_cmd_t c;
		c.mode = m;
		c.value = v;
		c.ramp_time_ms = t;
		pending_cmds.push_back(c);
	endtask

	task automatic push_tick();
		push_cmd(MODE_TICK, $urandom, RTIME_W'($urandom));
	endtask

	function automatic logic signed [VAL_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return LEVEL_MAX;
			1: return LEVEL_MIN;
			2: return '0;
			3: return (32'($urandom_range(0, 20)) - 32'd10) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_sequence(input int unsigned gran, output int used);
		int unsigned eff;
		int unsigned n;
		int unsigned nmax;
		int unsigned rem;
		int unsigned kind;
		eff = (gran == 0) ? 1 : gran;
		nmax = 16777215 / eff;
		kind = $urandom_range(0, 9);
		used = 0;
		if (kind <= 6) begin
			if (kind == 0)
				n = $urandom_range(1, 3);
			else if ($urandom_range(0, 15) == 0)
				n = $urandom_range(100, 300);
			else
				n = $urandom_range(1, 24);
			if (n > nmax)
				n = nmax;
			rem = 16777215 - n * eff;
			if (rem > eff - 1)
				rem = eff - 1;
			if (kind == 1) begin
				push_cmd(MODE_SET, pick_level(), RTIME_W'($urandom));
				used++;
			end
			push_cmd(MODE_GO, pick_level(), RTIME_W'(n * eff + $urandom_range(0, rem)));
			repeat (n - 1)
				push_tick();
			used += n;
			repeat ($urandom_range(0, 1))
				push_tick();
		end else if (kind == 7) begin
			push_cmd(MODE_GO, pick_level(), RTIME_W'($urandom));
			repeat ($urandom_range(0, 5))
				push_tick();
			case ($urandom_range(0, 2))
				0: push_cmd(MODE_STOP, $urandom, RTIME_W'($urandom));
				1: push_cmd(MODE_SET, pick_level(), RTIME_W'($urandom));
				default: push_cmd(MODE_GO, pick_level(), RTIME_W'($urandom_range(0, 4 * eff)));
			endcase
			used = 8;
		end else if (kind == 8) begin
			push_cmd(MODE_SET, pick_level(), RTIME_W'($urandom));
			push_cmd(MODE_STOP, $urandom, RTIME_W'($urandom));
			push_tick();
			used = 2;
		end else begin
			repeat ($urandom_range(1, 6)) begin
				push_cmd(mode_t'($urandom_range(0, 3)), $urandom, RTIME_W'($urandom));
				used++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmd_ch.valid || ramp_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_granularity(logic [GRAN_W-1:0] g);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int unsigned gran_plan[NUM_PHASES];
		int budget;
		int used;
		gran_plan = '{1, 65535, 0, 7, 20, 1000, 3};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_TICK;
		cmd_ch.value = '0;
		cmd_ch.ramp_time_ms = '0;
		ramp_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed part at reset granularity
		push_cmd(MODE_TICK, '0, '0);
		push_cmd(MODE_STOP, '0, '0);
		push_cmd(MODE_GO, LEVEL_MAX, '0);
		push_cmd(MODE_GO, LEVEL_MIN, 24'd100);
		repeat (4) push_cmd(MODE_TICK, '1, RTIME_MAX);
		push_cmd(MODE_TICK, '0, '0);
		push_cmd(MODE_SET, LEVEL_MAX, '0);
		push_cmd(MODE_GO, LEVEL_MIN, RTIME_MAX);
		repeat (2) push_cmd(MODE_TICK, '0, '0);
		push_cmd(MODE_GO, 32'sh0005_0000, 24'd200);
		push_cmd(MODE_TICK, '0, '0);
		push_cmd(MODE_STOP, '1, RTIME_MAX);
		push_cmd(MODE_TICK, '0, '0);
		push_cmd(MODE_SET, -32'sd1, '0);
		push_cmd(MODE_GO, 32'sh0001_0000, 24'd19);
		push_cmd(MODE_GO, '0, 24'd60);
		repeat (2) push_cmd(MODE_TICK, '0, '0);
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == NUM_PHASES - 1)
				gran_plan[ph] = $urandom_range(2, 65534);
			write_granularity(GRAN_W'(gran_plan[ph]));
			budget = 0;
			while (budget < PHASE_ITEMS) begin
				queue_sequence(gran_plan[ph], used);
				budget += used;
			end
			wait_drained();
		end

		if (ramp_expected.size() != 0) begin
			$display("%0t: %0d expected transactions never arrived", $time,
				ramp_expected.size());
			errors++;
		end
		$display("run covered %0d commands and %0d ramp points over %0d granularity settings",
			items_accepted, results_seen, NUM_PHASES + 1);
		$display("including zero, minimum and maximum granularity and full-scale ramps");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
